### hdl/vrt_pkg.sv
package vrt_pkg;

    // Field widths
    localparam int PosW     = 32;
    localparam int NrmW     = 16;
    localparam int QW       = 16;
    localparam int ScaleW   = 24;
    localparam int OffW     = 32;
    localparam int TexW     = 32;
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 32;

    // Fixed-point constants
    localparam int QFrac     = 14;
    localparam int QHalf     = 8192;
    localparam int ScaleFrac = 16;
    localparam int ScaleHalf = 32768;
    localparam int NrmMax    = 16384;

    // Growth of a rotated component over its input width
    localparam int RotGrow = QW + 8 - QFrac;

    // Pipeline depths
    localparam int RotLatency  = 4;
    localparam int PostLatency = 2;
    localparam int PipeDepth   = RotLatency + PostLatency;

    // Reset values
    localparam int RotWReset  = 16384;
    localparam int ScaleReset = 65536;

    // Cyclic component order for cross products
    localparam int NextIdx [3] = '{1, 2, 0};
    localparam int PrevIdx [3] = '{2, 0, 1};

    typedef enum logic [CfgAddrW-1:0] {
        RegRotW    = 3'd0,
        RegRotX    = 3'd1,
        RegRotY    = 3'd2,
        RegRotZ    = 3'd3,
        RegScale   = 3'd4,
        RegOffsetX = 3'd5,
        RegOffsetY = 3'd6,
        RegOffsetZ = 3'd7
    } cfg_reg_e_t;

    typedef struct packed {
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
    } rot_cfg_t;

endpackage

### hdl/vrt_rotate.sv
module vrt_rotate #(
    parameter int VW = vrt_pkg::PosW
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      vld_in,
    input  vrt_pkg::rot_cfg_t                         rot,
    input  logic signed [VW-1:0]                      vx,
    input  logic signed [VW-1:0]                      vy,
    input  logic signed [VW-1:0]                      vz,
    output logic                                      vld_out,
    output logic signed [VW+vrt_pkg::RotGrow-1:0]     rx,
    output logic signed [VW+vrt_pkg::RotGrow-1:0]     ry,
    output logic signed [VW+vrt_pkg::RotGrow-1:0]     rz
);

    localparam int QW  = vrt_pkg::QW;
    localparam int PW  = VW + QW;
    localparam int CXW = PW + 3;
    localparam int TW  = CXW - vrt_pkg::QFrac;
    localparam int MW  = TW + QW;
    localparam int RW  = VW + vrt_pkg::RotGrow;
    localparam int AW  = RW + vrt_pkg::QFrac;

    logic signed [VW-1:0]  v_in [3];
    logic signed [QW-1:0]  q [3];

    logic [vrt_pkg::RotLatency-1:0] vld_reg;

    logic signed [PW-1:0]  pa_reg [3];
    logic signed [PW-1:0]  pa_next [3];
    logic signed [PW-1:0]  pb_reg [3];
    logic signed [PW-1:0]  pb_next [3];
    logic signed [VW-1:0]  v1_reg [3];

    logic signed [CXW-1:0] c2 [3];
    logic signed [CXW-1:0] rnd2 [3];
    logic signed [TW-1:0]  t_reg [3];
    logic signed [TW-1:0]  t_next [3];
    logic signed [VW-1:0]  v2_reg [3];

    logic signed [MW-1:0]  wt_reg [3];
    logic signed [MW-1:0]  wt_next [3];
    logic signed [MW-1:0]  ta_reg [3];
    logic signed [MW-1:0]  ta_next [3];
    logic signed [MW-1:0]  tb_reg [3];
    logic signed [MW-1:0]  tb_next [3];
    logic signed [VW-1:0]  v3_reg [3];

    logic signed [AW-1:0]  acc [3];
    logic signed [RW-1:0]  r_reg [3];
    logic signed [RW-1:0]  r_next [3];

    assign v_in[0] = vx;
    assign v_in[1] = vy;
    assign v_in[2] = vz;
    assign q[0]    = rot.x;
    assign q[1]    = rot.y;
    assign q[2]    = rot.z;

    // Stage 1: partial products of q.vec x v
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pa_next[i] = PW'(q[vrt_pkg::NextIdx[i]]) * PW'(v_in[vrt_pkg::PrevIdx[i]]);
            pb_next[i] = PW'(q[vrt_pkg::PrevIdx[i]]) * PW'(v_in[vrt_pkg::NextIdx[i]]);
        end
    end

    // Stage 2: difference, double and round to the vector format
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c2[i]     = CXW'(pa_reg[i]) - CXW'(pb_reg[i]);
            rnd2[i]   = (c2[i] <<< 1) + CXW'(vrt_pkg::QHalf);
            t_next[i] = TW'(rnd2[i] >>> vrt_pkg::QFrac);
        end
    end

    // Stage 3: w*t and the partial products of q.vec x t
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wt_next[i] = MW'(rot.w) * MW'(t_reg[i]);
            ta_next[i] = MW'(q[vrt_pkg::NextIdx[i]]) * MW'(t_reg[vrt_pkg::PrevIdx[i]]);
            tb_next[i] = MW'(q[vrt_pkg::PrevIdx[i]]) * MW'(t_reg[vrt_pkg::NextIdx[i]]);
        end
    end

    // Stage 4: sum all terms and round back to the vector format
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = (AW'(v3_reg[i]) <<< vrt_pkg::QFrac) + AW'(wt_reg[i])
                     + AW'(ta_reg[i]) - AW'(tb_reg[i]) + AW'(vrt_pkg::QHalf);
            r_next[i] = RW'(acc[i] >>> vrt_pkg::QFrac);
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[vrt_pkg::RotLatency-2:0], vld_in};
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pa_reg[i] <= pa_next[i];
            pb_reg[i] <= pb_next[i];
            v1_reg[i] <= v_in[i];
            t_reg[i]  <= t_next[i];
            v2_reg[i] <= v1_reg[i];
            wt_reg[i] <= wt_next[i];
            ta_reg[i] <= ta_next[i];
            tb_reg[i] <= tb_next[i];
            v3_reg[i] <= v2_reg[i];
            r_reg[i]  <= r_next[i];
        end
    end

    assign vld_out = vld_reg[vrt_pkg::RotLatency-1];
    assign rx      = r_reg[0];
    assign ry      = r_reg[1];
    assign rz      = r_reg[2];

endmodule

### hdl/vrt_scale_offset.sv
module vrt_scale_offset #(
    parameter int RW = vrt_pkg::PosW + vrt_pkg::RotGrow
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               vld_in,
    input  logic signed [RW-1:0]               r_in,
    input  logic [vrt_pkg::ScaleW-1:0]         scale,
    input  logic signed [vrt_pkg::OffW-1:0]    offset,
    output logic                               vld_out,
    output logic signed [vrt_pkg::PosW-1:0]    pos_out
);

    localparam int OutW = vrt_pkg::PosW;
    localparam int PW   = RW + vrt_pkg::ScaleW + 1;
    localparam int SW   = PW - vrt_pkg::ScaleFrac;
    localparam int OW   = SW + 1;

    localparam logic signed [OW-1:0] SatMax = OW'($signed({1'b0, {(OutW-1){1'b1}}}));
    localparam logic signed [OW-1:0] SatMin = OW'($signed({1'b1, {(OutW-1){1'b0}}}));

    logic                   vld1_reg;
    logic                   vld2_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [PW-1:0]   prod_next;
    logic signed [PW-1:0]   rnd;
    logic signed [SW-1:0]   scaled;
    logic signed [OW-1:0]   sum;
    logic signed [OutW-1:0] pos_reg;
    logic signed [OutW-1:0] pos_next;

    // Stage 1: multiply by the unsigned scale
    assign prod_next = PW'(r_in) * PW'($signed({1'b0, scale}));

    // Stage 2: round off the scale fraction, add the offset and saturate
    always_comb
    begin
        rnd    = prod_reg + PW'(vrt_pkg::ScaleHalf);
        scaled = SW'(rnd >>> vrt_pkg::ScaleFrac);
        sum    = OW'(scaled) + OW'(offset);
        if (sum > SatMax)
        begin
            pos_next = OutW'(SatMax);
        end
        else if (sum < SatMin)
        begin
            pos_next = OutW'(SatMin);
        end
        else
        begin
            pos_next = OutW'(sum);
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= vld_in;
            vld2_reg <= vld1_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        pos_reg  <= pos_next;
    end

    assign vld_out = vld2_reg;
    assign pos_out = pos_reg;

endmodule

### hdl/vertex_rigid_transform.sv
// Vertex rigid transform: rotate by a unit quaternion, scale and translate.
//
// Input: one vertex is transferred at each rising edge with start high and
// busy low. busy is always low, so a vertex may enter in every cycle.
// Output: done is high for exactly one cycle with the transformed vertex on
// out_pos_*, out_nrm_* and out_tex_*; the receiver cannot stall, and results
// leave in the order the vertices entered.
// From the input transfer to done, a vertex passes through these stages:
// four stages of rotation (cross-product multiply, round, second multiply,
// sum and round), then scale multiply and offset-add with saturation.
// Throughput is one vertex per cycle, set by the fully pipelined multipliers.
// Configuration: cfg_wr_en, cfg_addr, cfg_data write one register per edge
// (rot_w, rot_x, rot_y, rot_z, scale_factor, offset_x, offset_y, offset_z);
// write only while the pipeline holds no vertex.
// Reset clears the pipeline valid bits and loads the identity transform
// (rotation w = 1.0, scale 1.0, zero offset).
module vertex_rigid_transform (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [vrt_pkg::PosW-1:0]        pos_x,
    input  logic signed [vrt_pkg::PosW-1:0]        pos_y,
    input  logic signed [vrt_pkg::PosW-1:0]        pos_z,
    input  logic signed [vrt_pkg::NrmW-1:0]        nrm_x,
    input  logic signed [vrt_pkg::NrmW-1:0]        nrm_y,
    input  logic signed [vrt_pkg::NrmW-1:0]        nrm_z,
    input  logic [vrt_pkg::TexW-1:0]               tex_u,
    input  logic [vrt_pkg::TexW-1:0]               tex_v,
    input  logic                                   cfg_wr_en,
    input  logic [vrt_pkg::CfgAddrW-1:0]           cfg_addr,
    input  logic [vrt_pkg::CfgDataW-1:0]           cfg_data,
    output logic                                   done,
    output logic signed [vrt_pkg::PosW-1:0]        out_pos_x,
    output logic signed [vrt_pkg::PosW-1:0]        out_pos_y,
    output logic signed [vrt_pkg::PosW-1:0]        out_pos_z,
    output logic signed [vrt_pkg::NrmW-1:0]        out_nrm_x,
    output logic signed [vrt_pkg::NrmW-1:0]        out_nrm_y,
    output logic signed [vrt_pkg::NrmW-1:0]        out_nrm_z,
    output logic [vrt_pkg::TexW-1:0]               out_tex_u,
    output logic [vrt_pkg::TexW-1:0]               out_tex_v
);

    localparam int QW    = vrt_pkg::QW;
    localparam int NrmW  = vrt_pkg::NrmW;
    localparam int PosRW = vrt_pkg::PosW + vrt_pkg::RotGrow;
    localparam int NrmRW = NrmW + vrt_pkg::RotGrow;
    localparam int Depth = vrt_pkg::PipeDepth;

    localparam logic signed [NrmRW-1:0] NrmHi = NrmRW'(vrt_pkg::NrmMax);
    localparam logic signed [NrmRW-1:0] NrmLo = -NrmRW'(vrt_pkg::NrmMax);

    // Configuration registers
    logic signed [QW-1:0]               rot_w_reg;
    logic signed [QW-1:0]               rot_x_reg;
    logic signed [QW-1:0]               rot_y_reg;
    logic signed [QW-1:0]               rot_z_reg;
    logic [vrt_pkg::ScaleW-1:0]         scale_reg;
    logic signed [vrt_pkg::OffW-1:0]    offset_x_reg;
    logic signed [vrt_pkg::OffW-1:0]    offset_y_reg;
    logic signed [vrt_pkg::OffW-1:0]    offset_z_reg;
    vrt_pkg::rot_cfg_t                  rot;

    logic                    accept;
    logic                    pos_vld;
    logic                    nrm_vld;
    logic signed [PosRW-1:0] pos_rx;
    logic signed [PosRW-1:0] pos_ry;
    logic signed [PosRW-1:0] pos_rz;
    logic signed [NrmRW-1:0] nrm_r [3];
    logic signed [NrmW-1:0]  nrm_sat_next [3];
    logic signed [NrmW-1:0]  nrm_sat_reg [3];
    logic signed [NrmW-1:0]  nrm_out_reg [3];
    logic                    vld_x;
    logic                    vld_y;
    logic                    vld_z;
    logic [vrt_pkg::TexW-1:0] tex_u_reg [Depth];
    logic [vrt_pkg::TexW-1:0] tex_v_reg [Depth];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_w_reg    <= QW'(vrt_pkg::RotWReset);
            rot_x_reg    <= '0;
            rot_y_reg    <= '0;
            rot_z_reg    <= '0;
            scale_reg    <= vrt_pkg::ScaleW'(vrt_pkg::ScaleReset);
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (vrt_pkg::cfg_reg_e_t'(cfg_addr))
                vrt_pkg::RegRotW:    rot_w_reg    <= cfg_data[QW-1:0];
                vrt_pkg::RegRotX:    rot_x_reg    <= cfg_data[QW-1:0];
                vrt_pkg::RegRotY:    rot_y_reg    <= cfg_data[QW-1:0];
                vrt_pkg::RegRotZ:    rot_z_reg    <= cfg_data[QW-1:0];
                vrt_pkg::RegScale:   scale_reg    <= cfg_data[vrt_pkg::ScaleW-1:0];
                vrt_pkg::RegOffsetX: offset_x_reg <= cfg_data[vrt_pkg::OffW-1:0];
                vrt_pkg::RegOffsetY: offset_y_reg <= cfg_data[vrt_pkg::OffW-1:0];
                vrt_pkg::RegOffsetZ: offset_z_reg <= cfg_data[vrt_pkg::OffW-1:0];
                default:             ;
            endcase
        end
    end

    assign rot.w = rot_w_reg;
    assign rot.x = rot_x_reg;
    assign rot.y = rot_y_reg;
    assign rot.z = rot_z_reg;

    // Rotate the position
    vrt_rotate #(
        .VW (vrt_pkg::PosW)
    ) u_pos_rotate (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (accept),
        .rot     (rot),
        .vx      (pos_x),
        .vy      (pos_y),
        .vz      (pos_z),
        .vld_out (pos_vld),
        .rx      (pos_rx),
        .ry      (pos_ry),
        .rz      (pos_rz)
    );

    // Rotate the normal
    vrt_rotate #(
        .VW (NrmW)
    ) u_nrm_rotate (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (accept),
        .rot     (rot),
        .vx      (nrm_x),
        .vy      (nrm_y),
        .vz      (nrm_z),
        .vld_out (nrm_vld),
        .rx      (nrm_r[0]),
        .ry      (nrm_r[1]),
        .rz      (nrm_r[2])
    );

    // Scale and translate the position, one unit per axis
    vrt_scale_offset #(
        .RW (PosRW)
    ) u_scale_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (pos_vld),
        .r_in    (pos_rx),
        .scale   (scale_reg),
        .offset  (offset_x_reg),
        .vld_out (vld_x),
        .pos_out (out_pos_x)
    );

    vrt_scale_offset #(
        .RW (PosRW)
    ) u_scale_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (pos_vld),
        .r_in    (pos_ry),
        .scale   (scale_reg),
        .offset  (offset_y_reg),
        .vld_out (vld_y),
        .pos_out (out_pos_y)
    );

    vrt_scale_offset #(
        .RW (PosRW)
    ) u_scale_z (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (pos_vld),
        .r_in    (pos_rz),
        .scale   (scale_reg),
        .offset  (offset_z_reg),
        .vld_out (vld_z),
        .pos_out (out_pos_z)
    );

    // Saturate the rotated normal to the unit range
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (nrm_r[i] > NrmHi)
            begin
                nrm_sat_next[i] = NrmW'(NrmHi);
            end
            else if (nrm_r[i] < NrmLo)
            begin
                nrm_sat_next[i] = NrmW'(NrmLo);
            end
            else
            begin
                nrm_sat_next[i] = NrmW'(nrm_r[i]);
            end
        end
    end

    // Hold the normal and texture words in step with the position path
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            nrm_sat_reg[i] <= nrm_sat_next[i];
            nrm_out_reg[i] <= nrm_sat_reg[i];
        end
        tex_u_reg[0] <= tex_u;
        tex_v_reg[0] <= tex_v;
        for (int k = 1; k < Depth; k++)
        begin
            tex_u_reg[k] <= tex_u_reg[k-1];
            tex_v_reg[k] <= tex_v_reg[k-1];
        end
    end

    assign done      = vld_x;
    assign out_nrm_x = nrm_out_reg[0];
    assign out_nrm_y = nrm_out_reg[1];
    assign out_nrm_z = nrm_out_reg[2];
    assign out_tex_u = tex_u_reg[Depth-1];
    assign out_tex_v = tex_v_reg[Depth-1];

    // Position and normal rotators run in lockstep
    a_rot_align: assert property (@(posedge clk) disable iff (!rst_n)
        nrm_vld == pos_vld)
        else $error("normal and position rotators out of step");

    // All three axis units agree on the result strobe
    a_axis_align: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_x == vld_y) && (vld_x == vld_z))
        else $error("axis units out of step");

    // Every result stems from an earlier input transfer
    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 6))
        else $error("result without a matching input transfer");

    // Texture words arrive unchanged with their vertex
    a_tex_pass: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_tex_u == $past(tex_u, 6)) && (out_tex_v == $past(tex_v, 6)))
        else $error("texture word corrupted in flight");

    // Normal results stay within the unit range
    a_nrm_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_nrm_x <= NrmW'(vrt_pkg::NrmMax)) && (out_nrm_x >= -NrmW'(vrt_pkg::NrmMax))
              && (out_nrm_y <= NrmW'(vrt_pkg::NrmMax)) && (out_nrm_y >= -NrmW'(vrt_pkg::NrmMax))
              && (out_nrm_z <= NrmW'(vrt_pkg::NrmMax)) && (out_nrm_z >= -NrmW'(vrt_pkg::NrmMax)))
        else $error("normal result outside unit range");

endmodule

### sim/vertex_rigid_transform_test.sv
module vertex_rigid_transform_test;

    import vrt_pkg::*;

    typedef struct packed {
        logic signed [PosW-1:0] px;
        logic signed [PosW-1:0] py;
        logic signed [PosW-1:0] pz;
        logic signed [NrmW-1:0] nx;
        logic signed [NrmW-1:0] ny;
        logic signed [NrmW-1:0] nz;
        logic [TexW-1:0]        u;
        logic [TexW-1:0]        v;
    } vertex_t;

    typedef struct packed {
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] c;
    } vec3_t;

    localparam longint QOne  = longint'(1) <<< QFrac;
    localparam longint PosHi = (longint'(1) <<< (PosW - 1)) - 1;
    localparam longint PosLo = -(longint'(1) <<< (PosW - 1));

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    start     = 1'b0;
    logic                    busy;
    logic signed [PosW-1:0]  pos_x     = '0;
    logic signed [PosW-1:0]  pos_y     = '0;
    logic signed [PosW-1:0]  pos_z     = '0;
    logic signed [NrmW-1:0]  nrm_x     = '0;
    logic signed [NrmW-1:0]  nrm_y     = '0;
    logic signed [NrmW-1:0]  nrm_z     = '0;
    logic [TexW-1:0]         tex_u     = '0;
    logic [TexW-1:0]         tex_v     = '0;
    logic                    cfg_wr_en = 1'b0;
    logic [CfgAddrW-1:0]     cfg_addr  = '0;
    logic [CfgDataW-1:0]     cfg_data  = '0;
    logic                    done;
    logic signed [PosW-1:0]  out_pos_x;
    logic signed [PosW-1:0]  out_pos_y;
    logic signed [PosW-1:0]  out_pos_z;
    logic signed [NrmW-1:0]  out_nrm_x;
    logic signed [NrmW-1:0]  out_nrm_y;
    logic signed [NrmW-1:0]  out_nrm_z;
    logic [TexW-1:0]         out_tex_u;
    logic [TexW-1:0]         out_tex_v;

    // Shadow copy of the transform registers
    logic signed [QW-1:0]    shadow_rot_w = 16'(RotWReset);
    logic signed [QW-1:0]    shadow_rot_x = '0;
    logic signed [QW-1:0]    shadow_rot_y = '0;
    logic signed [QW-1:0]    shadow_rot_z = '0;
    logic [ScaleW-1:0]       shadow_scale = 24'(ScaleReset);
    logic signed [OffW-1:0]  shadow_off_x = '0;
    logic signed [OffW-1:0]  shadow_off_y = '0;
    logic signed [OffW-1:0]  shadow_off_z = '0;

    vertex_t                 vertex_backlog[$];
    vertex_t                 transformed_due[$];
    vertex_t                 cur_vertex;
    vertex_t                 want;
    int                      gap_left  = 0;
    bit                      dense     = 1'b0;
    int                      err_count = 0;

    vertex_rigid_transform dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .nrm_x     (nrm_x),
        .nrm_y     (nrm_y),
        .nrm_z     (nrm_z),
        .tex_u     (tex_u),
        .tex_v     (tex_v),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .done      (done),
        .out_pos_x (out_pos_x),
        .out_pos_y (out_pos_y),
        .out_pos_z (out_pos_z),
        .out_nrm_x (out_nrm_x),
        .out_nrm_y (out_nrm_y),
        .out_nrm_z (out_nrm_z),
        .out_tex_u (out_tex_u),
        .out_tex_v (out_tex_v)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Append a vertex to the pending stimulus
    function automatic void queue_vertex(input vertex_t vq);
        vertex_backlog.insert(vertex_backlog.size(), vq);
    endfunction

    // Append an expected result
    function automatic void queue_expect(input vertex_t vq);
        transformed_due.insert(transformed_due.size(), vq);
    endfunction

    // Rotate a vector by the shadow quaternion: t = 2(q x v), v' = v + w*t + q x t
    function automatic vec3_t rotate_vec(input longint v0, input longint v1,
                                         input longint v2);
        longint w, qx, qy, qz, t0, t1, t2;
        vec3_t  r;
        w  = longint'(shadow_rot_w);
        qx = longint'(shadow_rot_x);
        qy = longint'(shadow_rot_y);
        qz = longint'(shadow_rot_z);
        t0 = (2 * (qy * v2 - qz * v1) + QHalf) >>> QFrac;
        t1 = (2 * (qz * v0 - qx * v2) + QHalf) >>> QFrac;
        t2 = (2 * (qx * v1 - qy * v0) + QHalf) >>> QFrac;
        r.a = (v0 * QOne + w * t0 + (qy * t2 - qz * t1) + QHalf) >>> QFrac;
        r.b = (v1 * QOne + w * t1 + (qz * t0 - qx * t2) + QHalf) >>> QFrac;
        r.c = (v2 * QOne + w * t2 + (qx * t1 - qy * t0) + QHalf) >>> QFrac;
        return r;
    endfunction

    function automatic logic signed [PosW-1:0] sat_pos(input longint x);
        longint y;
        y = (x > PosHi) ? PosHi : ((x < PosLo) ? PosLo : x);
        return y[PosW-1:0];
    endfunction

    function automatic logic signed [NrmW-1:0] sat_nrm(input longint x);
        longint y;
        y = (x > NrmMax) ? NrmMax : ((x < -NrmMax) ? -NrmMax : x);
        return y[NrmW-1:0];
    endfunction

    // Expected output vertex for one input vertex under the shadow registers
    function automatic vertex_t transform_vertex(input vertex_t vin);
        vec3_t   rp, rn;
        longint  sc;
        vertex_t vout;
        rp = rotate_vec(longint'(vin.px), longint'(vin.py), longint'(vin.pz));
        rn = rotate_vec(longint'(vin.nx), longint'(vin.ny), longint'(vin.nz));
        sc = longint'(shadow_scale);
        vout.px = sat_pos(((rp.a * sc + ScaleHalf) >>> ScaleFrac) + longint'(shadow_off_x));
        vout.py = sat_pos(((rp.b * sc + ScaleHalf) >>> ScaleFrac) + longint'(shadow_off_y));
        vout.pz = sat_pos(((rp.c * sc + ScaleHalf) >>> ScaleFrac) + longint'(shadow_off_z));
        vout.nx = sat_nrm(rn.a);
        vout.ny = sat_nrm(rn.b);
        vout.nz = sat_nrm(rn.c);
        vout.u  = vin.u;
        vout.v  = vin.v;
        return vout;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (dense)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: record the transfer, then hold, idle or present the next vertex
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (start && busy == 1'b0)
            begin
                queue_expect(transform_vertex(cur_vertex));
                gap_left = pick_gap();
            end
            if (start && busy != 1'b0)
            begin
                start <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (vertex_backlog.size() != 0)
            begin
                cur_vertex = vertex_backlog.pop_front();
                pos_x <= cur_vertex.px;
                pos_y <= cur_vertex.py;
                pos_z <= cur_vertex.pz;
                nrm_x <= cur_vertex.nx;
                nrm_y <= cur_vertex.ny;
                nrm_z <= cur_vertex.nz;
                tex_u <= cur_vertex.u;
                tex_v <= cur_vertex.v;
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h",
                     $time, name, exp_val, act_val);
            err_count++;
        end
    endtask

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (transformed_due.size() == 0)
            begin
                $display("%0t: result with no vertex outstanding", $time);
                err_count++;
            end
            else
            begin
                want = transformed_due.pop_front();
                check_field("out_pos_x", 64'(want.px), 64'(out_pos_x));
                check_field("out_pos_y", 64'(want.py), 64'(out_pos_y));
                check_field("out_pos_z", 64'(want.pz), 64'(out_pos_z));
                check_field("out_nrm_x", 64'(want.nx), 64'(out_nrm_x));
                check_field("out_nrm_y", 64'(want.ny), 64'(out_nrm_y));
                check_field("out_nrm_z", 64'(want.nz), 64'(out_nrm_z));
                check_field("out_tex_u", 64'(want.u), 64'(out_tex_u));
                check_field("out_tex_v", 64'(want.v), 64'(out_tex_v));
            end
        end
    end

    // Sample away from the active edge so the driver's updates have settled
    task automatic wait_idle();
        while (vertex_backlog.size() != 0 || start || transformed_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_e_t idx, input logic [CfgDataW-1:0] value);
        case (idx)
            RegRotW:    shadow_rot_w = value[QW-1:0];
            RegRotX:    shadow_rot_x = value[QW-1:0];
            RegRotY:    shadow_rot_y = value[QW-1:0];
            RegRotZ:    shadow_rot_z = value[QW-1:0];
            RegScale:   shadow_scale = value[ScaleW-1:0];
            RegOffsetX: shadow_off_x = value;
            RegOffsetY: shadow_off_y = value;
            RegOffsetZ: shadow_off_z = value;
            default:    ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
    endtask

    // Load all eight registers, with junk above the register width half the time
    task automatic apply_setting(input logic [QW-1:0] w, input logic [QW-1:0] x,
                                 input logic [QW-1:0] y, input logic [QW-1:0] z,
                                 input logic [ScaleW-1:0] sc, input logic [OffW-1:0] ox,
                                 input logic [OffW-1:0] oy, input logic [OffW-1:0] oz);
        logic [CfgDataW-1:0] junk;
        junk = ($urandom_range(1) == 1) ? $urandom : '0;
        write_reg(RegRotW, {junk[CfgDataW-1:QW], w});
        write_reg(RegRotX, {junk[CfgDataW-1:QW], x});
        write_reg(RegRotY, {junk[CfgDataW-1:QW], y});
        write_reg(RegRotZ, {junk[CfgDataW-1:QW], z});
        write_reg(RegScale, {junk[CfgDataW-1:ScaleW], sc});
        write_reg(RegOffsetX, ox);
        write_reg(RegOffsetY, oy);
        write_reg(RegOffsetZ, oz);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic add_corner_vertices();
        queue_vertex('{32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0});
        queue_vertex('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       16'h4000, 16'h4000, 16'h4000,
                       32'hffffffff, 32'hffffffff});
        queue_vertex('{32'h80000000, 32'h80000000, 32'h80000000,
                       16'hc000, 16'hc000, 16'hc000, 32'h0, 32'h0});
        queue_vertex('{32'h00000001, 32'hffffffff, 32'h00010000,
                       16'h0001, 16'hffff, 16'h0000,
                       32'ha5a5a5a5, 32'h5a5a5a5a});
        // normals outside the unit range
        queue_vertex('{32'h7fff0000, 32'h80010000, 32'h12345678,
                       16'h7fff, 16'h8000, 16'h4001,
                       32'h0000ffff, 32'hffff0000});
    endtask

    function automatic vertex_t random_vertex();
        vertex_t vr;
        if ($urandom_range(9) < 6)
        begin
            vr.px = $urandom_range(33554432) - 16777216;
            vr.py = $urandom_range(33554432) - 16777216;
            vr.pz = $urandom_range(33554432) - 16777216;
        end
        else
        begin
            vr.px = $urandom;
            vr.py = $urandom;
            vr.pz = $urandom;
        end
        if ($urandom_range(9) < 8)
        begin
            vr.nx = NrmW'($urandom_range(32768) - 16384);
            vr.ny = NrmW'($urandom_range(32768) - 16384);
            vr.nz = NrmW'($urandom_range(32768) - 16384);
        end
        else
        begin
            vr.nx = NrmW'($urandom);
            vr.ny = NrmW'($urandom);
            vr.nz = NrmW'($urandom);
        end
        vr.u = $urandom;
        vr.v = $urandom;
        return vr;
    endfunction

    // Stimulus: directed corners under four settings, then random phases
    initial
    begin
        int                  phase;
        int                  n;
        logic [QW-1:0]       qw, qx, qy, qz;
        logic [ScaleW-1:0]   sc;
        logic [OffW-1:0]     ox, oy, oz;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: identity transform
        add_corner_vertices();
        wait_idle();
        // half turn about x, saturating scale, extreme x and y offsets
        apply_setting(16'h0000, 16'h4000, 16'h0000, 16'h0000, 24'hffffff,
                      32'h7fffffff, 32'h80000000, 32'h0);
        add_corner_vertices();
        wait_idle();
        // most negative non-unit quaternion, zero scale
        apply_setting(16'h8000, 16'h8000, 16'h8000, 16'h8000, 24'h0,
                      32'h80000000, 32'h80000000, 32'h80000000);
        add_corner_vertices();
        wait_idle();
        // most positive non-unit quaternion, smallest scale step
        apply_setting(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 24'h000001,
                      32'h00000001, 32'hffffffff, 32'h7fffffff);
        add_corner_vertices();

        for (phase = 0; phase < 8; phase++)
        begin
            wait_idle();
            case (phase % 4)
                0:
                begin
                    case ($urandom_range(7))
                        0: {qw, qx, qy, qz} = {16'h4000, 16'h0000, 16'h0000, 16'h0000};
                        1: {qw, qx, qy, qz} = {16'h0000, 16'h4000, 16'h0000, 16'h0000};
                        2: {qw, qx, qy, qz} = {16'h0000, 16'h0000, 16'h4000, 16'h0000};
                        3: {qw, qx, qy, qz} = {16'h0000, 16'h0000, 16'h0000, 16'h4000};
                        4: {qw, qx, qy, qz} = {16'h2d41, 16'h2d41, 16'h0000, 16'h0000};
                        5: {qw, qx, qy, qz} = {16'h2d41, 16'h0000, 16'hd2bf, 16'h0000};
                        6: {qw, qx, qy, qz} = {16'h2000, 16'h2000, 16'h2000, 16'h2000};
                        default: {qw, qx, qy, qz} = {16'he000, 16'h2000, 16'he000, 16'h2000};
                    endcase
                    sc = ScaleW'($urandom_range(24'h03ffff));
                    ox = $urandom_range(2097152) - 1048576;
                    oy = $urandom_range(2097152) - 1048576;
                    oz = $urandom_range(2097152) - 1048576;
                end
                1:
                begin
                    qw = QW'($urandom_range(32768) - 16384);
                    qx = QW'($urandom_range(32768) - 16384);
                    qy = QW'($urandom_range(32768) - 16384);
                    qz = QW'($urandom_range(32768) - 16384);
                    sc = ScaleW'($urandom);
                    ox = $urandom;
                    oy = $urandom;
                    oz = $urandom;
                end
                2:
                begin
                    qw = QW'($urandom);
                    qx = QW'($urandom);
                    qy = QW'($urandom);
                    qz = QW'($urandom);
                    sc = ScaleW'($urandom_range(24'h01ffff));
                    ox = $urandom;
                    oy = $urandom;
                    oz = $urandom;
                end
                default:
                begin
                    qw = 16'h4000;
                    qx = 16'h0000;
                    qy = 16'h0000;
                    qz = 16'h0000;
                    sc = ($urandom_range(1) == 1) ? 24'hffffff : 24'h0;
                    ox = 32'h7fffffff;
                    oy = 32'h80000000;
                    oz = ($urandom_range(1) == 1) ? 32'h7fffffff : 32'h80000000;
                end
            endcase
            apply_setting(qw, qx, qy, qz, sc, ox, oy, oz);
            dense = (phase % 3 == 1);
            for (n = 0; n < 100; n++)
                queue_vertex(random_vertex());
        end

        // drain, then allow for any stray result
        wait_idle();
        repeat (PipeDepth + 4) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/vrt_pkg.sv
hdl/vrt_rotate.sv
hdl/vrt_scale_offset.sv
hdl/vertex_rigid_transform.sv
sim/vertex_rigid_transform_test.sv
